FILE: rtl/serial_message_framer_top_macros.svh
// Assertion macros for the serial message framer.
// Used by serial_message_framer_top.sv; the clock and reset names are fixed by that module.
`ifndef SERIAL_MESSAGE_FRAMER_TOP_MACROS_SVH
`define SERIAL_MESSAGE_FRAMER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SMF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/smf_pkg.sv
// Shared types, constants and byte-selection functions of the serial message framer.
// No dependencies; smf_frame_ctl, serial_message_framer_top and the testbench import it.
`timescale 1ns / 1ps

package smf_pkg;

    localparam logic [7:0] BYTE_START = 8'h8F;
    localparam logic [7:0] BYTE_STX   = 8'h02;
    localparam logic [7:0] BYTE_ETX   = 8'h03;
    localparam logic [7:0] BYTE_END   = 8'hCF;

    localparam logic [7:0] TYPE_POST    = 8'h01;
    localparam logic [7:0] TYPE_REPLY   = 8'h02;
    localparam logic [7:0] TYPE_ACK     = 8'h04;
    localparam logic [7:0] TYPE_NACK    = 8'h08;
    localparam logic [7:0] TYPE_UNKNOWN = 8'hFF;

    localparam logic [2:0] KIND_POST  = 3'd0;
    localparam logic [2:0] KIND_REPLY = 3'd1;
    localparam logic [2:0] KIND_ACK   = 3'd2;
    localparam logic [2:0] KIND_NACK  = 3'd3;

    localparam logic FUNC_BEGIN   = 1'b0;
    localparam logic FUNC_PAYLOAD = 1'b1;

    // Positions within a burst. A header burst starts at IDX_START, a payload
    // burst at IDX_BODY; both end at IDX_BODY or, with a trailer, IDX_END.
    localparam logic [2:0] IDX_START = 3'd0;
    localparam logic [2:0] IDX_TYPE  = 3'd1;
    localparam logic [2:0] IDX_LEN   = 3'd2;
    localparam logic [2:0] IDX_BODY  = 3'd3;
    localparam logic [2:0] IDX_ETX   = 3'd4;
    localparam logic [2:0] IDX_CSUM  = 3'd5;
    localparam logic [2:0] IDX_END   = 3'd6;

    // Everything needed to emit the bytes caused by one accepted item.
    typedef struct packed {
        logic       is_payload;
        logic [7:0] type_code;
        logic [7:0] length;
        logic [7:0] data;
        logic [7:0] csum;
        logic       trailer;
    } t_burst;

    function automatic logic [7:0] type_code(input logic [2:0] kind);
        logic [7:0] code;
        case (kind)
            KIND_POST:  code = TYPE_POST;
            KIND_REPLY: code = TYPE_REPLY;
            KIND_ACK:   code = TYPE_ACK;
            KIND_NACK:  code = TYPE_NACK;
            default:    code = TYPE_UNKNOWN;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] burst_byte(input t_burst burst, input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            IDX_START: b = BYTE_START;
            IDX_TYPE:  b = burst.type_code;
            IDX_LEN:   b = burst.length;
            IDX_BODY:  b = burst.is_payload ? burst.data : BYTE_STX;
            IDX_ETX:   b = BYTE_ETX;
            IDX_CSUM:  b = burst.csum;
            IDX_END:   b = BYTE_END;
            default:   b = BYTE_END;
        endcase
        return b;
    endfunction

    function automatic logic [2:0] burst_last_idx(input t_burst burst);
        return burst.trailer ? IDX_END : IDX_BODY;
    endfunction

endpackage

FILE: rtl/smf_if.sv
// Valid/ready channel interfaces for the input items and the frame bytes.
// Depends on nothing; used by serial_message_framer_top.
`timescale 1ns / 1ps

interface smf_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [2:0] mtype;
    logic [7:0] payload_length;
    logic [7:0] data_byte;

    modport source (output valid, func, mtype, payload_length, data_byte, input ready);
    modport sink   (input valid, func, mtype, payload_length, data_byte, output ready);
endinterface

interface smf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       run_last;

    modport source (output valid, frame_byte, frame_end, run_last, input ready);
    modport sink   (input valid, frame_byte, frame_end, run_last, output ready);
endinterface

FILE: rtl/smf_frame_ctl.sv
// Frame state (open flag, remaining count, running checksum) and burst builder.
// Depends on smf_pkg.
`timescale 1ns / 1ps

module smf_frame_ctl
    import smf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_func,
    input  logic [2:0] i_mtype,
    input  logic [7:0] i_payload_length,
    input  logic [7:0] i_data_byte,
    output logic       o_load,
    output t_burst     o_burst
);

    logic       r_in_frame;
    logic [7:0] r_bytes_left;
    logic [7:0] r_xor;
    logic       n_in_frame;
    logic [7:0] n_bytes_left;
    logic [7:0] n_xor;

    logic [7:0] w_xor_next;
    logic [7:0] w_left_next;
    logic       w_close;

    assign w_xor_next  = r_xor ^ i_data_byte;
    assign w_left_next = r_bytes_left - 8'd1;
    assign w_close     = (w_left_next == 8'd0);

    always_comb begin
        n_in_frame   = r_in_frame;
        n_bytes_left = r_bytes_left;
        n_xor        = r_xor;
        o_load       = 1'b0;

        o_burst.is_payload = (i_func == FUNC_PAYLOAD);
        o_burst.type_code  = type_code(i_mtype);
        o_burst.length     = i_payload_length;
        o_burst.data       = i_data_byte;
        o_burst.csum       = 8'h00;
        o_burst.trailer    = (i_payload_length == 8'd0);

        if (i_func == FUNC_BEGIN) begin
            o_load = i_accept;
            if (i_accept) begin
                n_in_frame   = (i_payload_length != 8'd0);
                n_bytes_left = i_payload_length;
                n_xor        = 8'h00;
            end
        end else begin
            // A payload byte outside a frame is dropped without a trace.
            o_burst.csum    = w_xor_next;
            o_burst.trailer = w_close;
            o_load          = i_accept && r_in_frame;
            if (i_accept && r_in_frame) begin
                n_xor        = w_xor_next;
                n_bytes_left = w_left_next;
                n_in_frame   = !w_close;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_bytes_left <= 8'd0;
            r_xor        <= 8'h00;
        end else begin
            r_in_frame   <= n_in_frame;
            r_bytes_left <= n_bytes_left;
            r_xor        <= n_xor;
        end
    end

endmodule

FILE: rtl/serial_message_framer_top.sv
// Top level of the serial message framer: input channel, burst register and output register.
// Depends on smf_pkg, smf_if, smf_frame_ctl and serial_message_framer_top_macros.svh.
`timescale 1ns / 1ps
//
// Usage:
// The input channel i_in carries items. A begin item (func 0) opens a frame and
// produces four header bytes: 0x8F, the type code, the length and 0x02. A payload
// item (func 1) produces its own byte and, when it is the last byte of the frame,
// the trailer 0x03, checksum, 0xCF. A begin with length zero produces all seven
// bytes at once. A payload item while no frame is open is accepted and dropped.
// The output channel o_out carries one frame byte per transfer, with frame_end on
// the closing 0xCF and run_last on the final byte caused by each input item.
// The first byte of an item passes through the burst register and then the output
// register before it is offered. While the receiver keeps ready high, one byte leaves
// per cycle; a plain payload item has one result byte, a header four, a trailer three
// more. The burst register frees up in the cycle its last byte moves to the output
// register, so payload items stream at one per cycle while the receiver keeps up.
// When the receiver stalls, the output register holds its byte and the burst
// register waits; input ready drops once the burst register is full.
// Reset (i_rst_n low, synchronous) closes any open frame and empties both registers.
//
`include "serial_message_framer_top_macros.svh"

module serial_message_framer_top
    import smf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    smf_in_if.sink     i_in,
    smf_out_if.source  o_out
);

    logic       w_accept;
    logic       w_load;
    t_burst     w_burst;

    // Burst register: the pending bytes of one item and the position within them.
    t_burst     r_burst;
    logic       r_burst_vld;
    logic [2:0] r_idx;

    // Output register facing the receiver.
    logic       r_out_vld;
    logic [7:0] r_out_byte;
    logic       r_out_end;
    logic       r_out_last;

    logic       w_out_load;
    logic       w_burst_done;
    logic [2:0] w_last_idx;

    assign w_last_idx   = burst_last_idx(r_burst);
    assign w_out_load   = r_burst_vld && (!r_out_vld || o_out.ready);
    assign w_burst_done = w_out_load && (r_idx == w_last_idx);

    // Ready whenever the burst register is empty or hands over its last byte now.
    assign i_in.ready = !r_burst_vld || w_burst_done;
    assign w_accept   = i_in.valid && i_in.ready;

    smf_frame_ctl u_frame_ctl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_func           (i_in.func),
        .i_mtype          (i_in.mtype),
        .i_payload_length (i_in.payload_length),
        .i_data_byte      (i_in.data_byte),
        .o_load           (w_load),
        .o_burst          (w_burst)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_vld <= 1'b0;
            r_idx       <= IDX_START;
        end else if (w_load) begin
            r_burst_vld <= 1'b1;
            r_idx       <= w_burst.is_payload ? IDX_BODY : IDX_START;
        end else if (w_burst_done) begin
            r_burst_vld <= 1'b0;
        end else if (w_out_load) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_burst <= w_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_byte <= burst_byte(r_burst, r_idx);
            r_out_end  <= (r_idx == IDX_END);
            r_out_last <= (r_idx == w_last_idx);
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.frame_byte = r_out_byte;
    assign o_out.frame_end  = r_out_end;
    assign o_out.run_last   = r_out_last;

    // The closing byte of a frame is always the last byte of its item.
    `SMF_ASSERT_SAME(a_end_is_last, o_out.valid && o_out.frame_end, o_out.run_last, "end w/o last")
    // A new burst is only taken when the previous one is gone or finishing.
    `SMF_ASSERT_SAME(a_no_overwrite, w_load, !r_burst_vld || w_burst_done, "burst overwritten")
    // The position never runs past the end of its burst.
    `SMF_ASSERT_SAME(a_idx_bound, r_burst_vld, r_idx <= w_last_idx, "burst index out of range")
    // A waiting burst keeps its position while the output register is blocked.
    `SMF_ASSERT_NEXT(a_idx_hold, r_burst_vld && !w_out_load, r_idx == $past(r_idx), "index moved")

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of serial_message_framer_top: a directed table, then random frames.
// Depends on smf_pkg and smf_if from the RTL; frame bytes are predicted by its own model.

module testbench;
    import smf_pkg::*;

    localparam int N_DIR       = 21;
    localparam int N_RAND      = 440;
    localparam int PRESSURE_AT = 80;
    localparam int PAUSE_AT    = 200;
    localparam int CALM_LO     = 250;
    localparam int CALM_HI     = 340;
    localparam int HOLD_LEN    = 60;
    localparam int SETTLE      = 10;
    localparam int MAX_SHOWN   = 10;
    localparam int MAX_CYCLES  = 200000;

    // Message types with no code of their own.
    localparam logic [2:0] KIND_RSV4 = 3'd4;
    localparam logic [2:0] KIND_RSV5 = 3'd5;
    localparam logic [2:0] KIND_RSV6 = 3'd6;
    localparam logic [2:0] KIND_RSV7 = 3'd7;

    typedef struct packed {
        logic       func;
        logic [2:0] mtype;
        logic [7:0] len;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [7:0] fbyte;
        logic       fend;
        logic       last;
    } t_frame_res;

    // One line of the directed table. Rows with typed set carry their bytes by hand.
    typedef struct packed {
        t_item           it;
        logic            typed;
        logic [2:0]      n;
        logic            closes;
        logic [0:6][7:0] bytes;
    } t_row;

    logic clk;
    logic rst_n;

    smf_in_if  in_ch();
    smf_out_if out_ch();

    serial_message_framer_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_frame_res pending_bytes[$];
    logic       frm_open;
    logic [7:0] frm_left;
    logic [7:0] frm_xor;
    int         n_err = 0;
    logic       hold_req;
    logic       calm;
    t_row       dir_rows [N_DIR];

    function automatic void note_error(input string msg);
        n_err++;
        if (n_err <= MAX_SHOWN) $display("%0t: %s", $time, msg);
    endfunction

    function automatic t_frame_res res_of(input logic [7:0] b, input logic e);
        return '{fbyte: b, fend: e, last: 1'b0};
    endfunction

    // Frame bytes caused by one accepted item; advances the framing state.
    function automatic int frame_bytes_for(input t_item it, output t_frame_res res [7]);
        int         k;
        logic [7:0] code;
        logic       closing;
        k = 0;
        closing = 1'b0;
        if (it.func == FUNC_BEGIN) begin
            case (it.mtype)
                KIND_POST:  code = TYPE_POST;
                KIND_REPLY: code = TYPE_REPLY;
                KIND_ACK:   code = TYPE_ACK;
                KIND_NACK:  code = TYPE_NACK;
                default:    code = TYPE_UNKNOWN;
            endcase
            res[0] = res_of(BYTE_START, 1'b0);
            res[1] = res_of(code, 1'b0);
            res[2] = res_of(it.len, 1'b0);
            res[3] = res_of(BYTE_STX, 1'b0);
            k = 4;
            frm_xor  = 8'h00;
            frm_left = it.len;
            frm_open = 1'b1;
            closing  = (it.len == 8'd0);
        end else if (frm_open) begin
            res[0] = res_of(it.data, 1'b0);
            k = 1;
            frm_xor  = frm_xor ^ it.data;
            frm_left = frm_left - 8'd1;
            closing  = (frm_left == 8'd0);
        end
        if (closing) begin
            res[k]     = res_of(BYTE_ETX, 1'b0);
            res[k + 1] = res_of(frm_xor, 1'b0);
            res[k + 2] = res_of(BYTE_END, 1'b1);
            k = k + 3;
            frm_open = 1'b0;
            frm_left = 8'd0;
        end
        if (k > 0) res[k - 1].last = 1'b1;
        return k;
    endfunction

    function automatic void expect_model(input t_item it);
        t_frame_res res [7];
        int         n;
        n = frame_bytes_for(it, res);
        for (int k = 0; k < n; k++) pending_bytes.push_back(res[k]);
    endfunction

    function automatic t_row lit(input logic f, input logic [2:0] t, input logic [7:0] l,
                                 input logic [7:0] d, input logic [2:0] nb, input logic cl,
                                 input logic [0:6][7:0] b);
        return '{it: '{f, t, l, d}, typed: 1'b1, n: nb, closes: cl, bytes: b};
    endfunction

    function automatic t_row chk(input logic f, input logic [2:0] t, input logic [7:0] l,
                                 input logic [7:0] d);
        return '{it: '{f, t, l, d}, typed: 1'b0, n: 3'd0, closes: 1'b0, bytes: '0};
    endfunction

    task automatic offer_item(input t_item it);
        in_ch.valid          <= 1'b1;
        in_ch.func           <= it.func;
        in_ch.mtype          <= it.mtype;
        in_ch.payload_length <= it.len;
        in_ch.data_byte      <= it.data;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
    endtask

    task automatic pause_input(input int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_bytes.size() != 0);
    endtask

    initial begin : clock_gen
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < MAX_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Receiving side: checks every transfer out, then picks ready for the next cycle.
    initial begin : byte_sink
        int         hold_cnt;
        t_frame_res want;
        hold_cnt = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
                if (pending_bytes.size() == 0) begin
                    note_error($sformatf("unexpected frame byte %02h", out_ch.frame_byte));
                end else begin
                    want = pending_bytes.pop_front();
                    if (out_ch.frame_byte !== want.fbyte || out_ch.frame_end !== want.fend ||
                        out_ch.run_last !== want.last) begin
                        note_error($sformatf(
                            "byte exp %02h got %02h, end exp %b got %b, last exp %b got %b",
                            want.fbyte, out_ch.frame_byte, want.fend, out_ch.frame_end,
                            want.last, out_ch.run_last));
                    end
                end
            end
            if (hold_req && hold_cnt < HOLD_LEN) begin
                out_ch.ready <= 1'b0;
                hold_cnt++;
            end else if (calm) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= 15);
            end
        end
    end

    initial begin : stimulus
        t_item      it;
        t_frame_res res [7];
        int         n;
        int         r;
        int         n_live;
        logic       calm_now;
        logic       was_open;
        logic       pressured;
        logic       paused;

        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.func           <= FUNC_BEGIN;
        in_ch.mtype          <= KIND_POST;
        in_ch.payload_length <= 8'h00;
        in_ch.data_byte      <= 8'h00;
        hold_req             <= 1'b0;
        calm                 <= 1'b0;
        frm_open = 1'b0;
        frm_left = 8'd0;
        frm_xor  = 8'd0;

        dir_rows = '{
            // Stray payload straight after reset: dropped.
            lit(FUNC_PAYLOAD, KIND_POST, 8'd0, 8'hFF, 3'd0, 1'b0, '0),
            // Zero length: header and trailer in one go, checksum zero.
            lit(FUNC_BEGIN, KIND_POST, 8'd0, 8'h00, 3'd7, 1'b1,
                {BYTE_START, TYPE_POST, 8'h00, BYTE_STX, BYTE_ETX, 8'h00, BYTE_END}),
            lit(FUNC_BEGIN, KIND_REPLY, 8'd1, 8'h00, 3'd4, 1'b0,
                {BYTE_START, TYPE_REPLY, 8'h01, BYTE_STX, 24'h0}),
            // A zero data byte still counts and closes this one-byte frame.
            lit(FUNC_PAYLOAD, KIND_POST, 8'd0, 8'h00, 3'd4, 1'b1,
                {8'h00, BYTE_ETX, 8'h00, BYTE_END, 24'h0}),
            lit(FUNC_BEGIN, KIND_ACK, 8'd3, 8'h00, 3'd4, 1'b0,
                {BYTE_START, TYPE_ACK, 8'h03, BYTE_STX, 24'h0}),
            chk(FUNC_PAYLOAD, KIND_POST, 8'd0, 8'hA5),
            chk(FUNC_PAYLOAD, KIND_NACK, 8'hFF, 8'hFF),
            chk(FUNC_PAYLOAD, KIND_RSV7, 8'h00, 8'h5A),
            // Stray payload after a closed frame.
            lit(FUNC_PAYLOAD, KIND_POST, 8'd0, 8'h12, 3'd0, 1'b0, '0),
            lit(FUNC_BEGIN, KIND_NACK, 8'd255, 8'h00, 3'd4, 1'b0,
                {BYTE_START, TYPE_NACK, 8'hFF, BYTE_STX, 24'h0}),
            chk(FUNC_PAYLOAD, KIND_POST, 8'd0, 8'h81),
            // Begin inside a frame abandons it; unknown type gives the catch-all code.
            lit(FUNC_BEGIN, KIND_RSV4, 8'd2, 8'h00, 3'd4, 1'b0,
                {BYTE_START, TYPE_UNKNOWN, 8'h02, BYTE_STX, 24'h0}),
            chk(FUNC_PAYLOAD, KIND_POST, 8'd0, 8'h3C),
            chk(FUNC_PAYLOAD, KIND_POST, 8'd0, 8'hC3),
            lit(FUNC_BEGIN, KIND_RSV5, 8'd0, 8'h00, 3'd7, 1'b1,
                {BYTE_START, TYPE_UNKNOWN, 8'h00, BYTE_STX, BYTE_ETX, 8'h00, BYTE_END}),
            lit(FUNC_BEGIN, KIND_RSV6, 8'd128, 8'h00, 3'd4, 1'b0,
                {BYTE_START, TYPE_UNKNOWN, 8'h80, BYTE_STX, 24'h0}),
            lit(FUNC_BEGIN, KIND_RSV7, 8'd0, 8'h00, 3'd7, 1'b1,
                {BYTE_START, TYPE_UNKNOWN, 8'h00, BYTE_STX, BYTE_ETX, 8'h00, BYTE_END}),
            lit(FUNC_PAYLOAD, KIND_POST, 8'd0, 8'h7E, 3'd0, 1'b0, '0),
            // Two equal bytes cancel in the checksum.
            chk(FUNC_BEGIN, KIND_POST, 8'd2, 8'h00),
            chk(FUNC_PAYLOAD, KIND_POST, 8'd0, 8'hFF),
            chk(FUNC_PAYLOAD, KIND_POST, 8'd0, 8'hFF)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if ($urandom_range(0, 99) < 15) pause_input($urandom_range(1, 3));
            offer_item(dir_rows[i].it);
            if (dir_rows[i].typed) begin
                // Keep the model in step, but check against the hand-typed bytes.
                n = frame_bytes_for(dir_rows[i].it, res);
                for (int k = 0; k < dir_rows[i].n; k++) begin
                    pending_bytes.push_back(t_frame_res'{
                        fbyte: dir_rows[i].bytes[k],
                        fend:  dir_rows[i].closes && (k == dir_rows[i].n - 1),
                        last:  (k == dir_rows[i].n - 1)});
                end
            end else begin
                expect_model(dir_rows[i].it);
            end
        end
        wait_drain();

        n_live    = 0;
        pressured = 1'b0;
        paused    = 1'b0;
        while (n_live < N_RAND) begin
            if (!pressured && n_live >= PRESSURE_AT) begin
                // The receiver holds off while a whole frame is pushed back to back.
                pressured = 1'b1;
                hold_req <= 1'b1;
                it = '{func: FUNC_BEGIN, mtype: KIND_ACK, len: 8'd24, data: 8'($urandom)};
                offer_item(it);
                expect_model(it);
                repeat (24) begin
                    it.func  = FUNC_PAYLOAD;
                    it.data  = 8'($urandom);
                    it.mtype = 3'($urandom_range(0, 7));
                    offer_item(it);
                    expect_model(it);
                end
                n_live += 25;
            end
            if (!paused && n_live >= PAUSE_AT) begin
                paused = 1'b1;
                wait_drain();
            end
            calm_now = (n_live >= CALM_LO && n_live < CALM_HI);
            calm <= calm_now;

            // Mostly complete frames; a few strays and abandoned frames as noise.
            r = $urandom_range(0, 99);
            if (frm_open) it.func = (r < 6) ? FUNC_BEGIN : FUNC_PAYLOAD;
            else it.func = (r < 8) ? FUNC_PAYLOAD : FUNC_BEGIN;
            it.mtype = 3'($urandom_range(0, 7));
            it.data  = 8'($urandom);
            r = $urandom_range(0, 99);
            if (r < 10) it.len = 8'd0;
            else if (r < 80) it.len = 8'($urandom_range(1, 8));
            else if (r < 97) it.len = 8'($urandom_range(9, 40));
            else it.len = 8'($urandom_range(0, 255));

            if (!calm_now && $urandom_range(0, 99) < 15) pause_input($urandom_range(1, 4));
            was_open = frm_open;
            offer_item(it);
            expect_model(it);
            if (it.func == FUNC_BEGIN || was_open) n_live++;
        end

        wait_drain();
        repeat (SETTLE) @(posedge clk);
        if (pending_bytes.size() != 0) note_error("frame bytes still outstanding at the end");
        if (n_err == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
